// ===== hdl/ihrd_pkg.sv =====
// Package for the Intel HEX record decoder.
// Holds the image and line limits, the character codes and the hex digit decoder.
// No dependencies; every other file of the block but ihrd_req_if uses it.
`timescale 1ns / 1ps
`default_nettype none

package ihrd_pkg;

   localparam int unsigned IMAGE_BYTES = 65536;
   localparam int unsigned MAX_LINE    = 1024;

   localparam int unsigned ADDR_W     = 16;
   localparam int unsigned SPAN_W     = 17;
   localparam int unsigned LINE_POS_W = $clog2(MAX_LINE);

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] BYTE_MASK  = 8'hFF;
   localparam int unsigned MIN_LINE  = 11;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic              is_hex;
      logic [3:0]        value;
   } hex_digit_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] write_address;
      logic [7:0]        write_byte;
      logic              file_ok;
      logic [SPAN_W-1:0] start_address;
      logic [SPAN_W-1:0] image_length;
   } rsp_fields_type;

   // Decodes 0-9, A-F and a-f; anything else is flagged as not a hex digit.
   function automatic hex_digit_type hex_digit(input logic [7:0] ch);
      hex_digit_type d;
      d.is_hex = 1'b1;
      d.value  = 4'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         d.value = ch[3:0];
      end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
         d.value = ch[3:0] + 4'd9;
      end else begin
         d.is_hex = 1'b0;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ihrd_req_if.sv =====
// Request channel of the Intel HEX record decoder: one text character per request.
// Does not depend on ihrd_pkg; fields are fixed width.
`timescale 1ns / 1ps
`default_nettype none

interface ihrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_file;

   modport source (output valid, output char_code, output end_of_file, input ready);
   modport sink   (input valid, input char_code, input end_of_file, output ready);
endinterface

`default_nettype wire

// ===== hdl/ihrd_rsp_if.sv =====
// Response channel of the Intel HEX record decoder: byte writes and the final report.
// Field widths come from ihrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ihrd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic [ihrd_pkg::ADDR_W-1:0]       write_address;
   logic [7:0]                        write_byte;
   logic                              file_ok;
   logic [ihrd_pkg::SPAN_W-1:0]       start_address;
   logic [ihrd_pkg::SPAN_W-1:0]       image_length;

   modport source (output valid, output kind, output write_address, output write_byte,
                   output file_ok, output start_address, output image_length,
                   input ready);
   modport sink   (input valid, input kind, input write_address, input write_byte,
                   input file_ok, input start_address, input image_length,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/intel_hex_record_decoder_core.sv =====
// Top level of the Intel HEX record decoder: line parser, span tracking and response buffer.
// Depends on ihrd_pkg, ihrd_req_if and ihrd_rsp_if.
//
//   channel  | dir | handshake          | payload
//   req_ch   | in  | valid/ready        | char_code, end_of_file
//   rsp_ch   | out | valid/ready        | kind, write_address, write_byte, file_ok,
//            |     |                    | start_address, image_length
//
// One character is parsed in the cycle it is accepted; its result, if any, is registered
// in the response register, or in the skid entry behind a stalled one. While that entry is
// empty a new request can be taken every cycle. The response side is a register plus a
// one-entry skid buffer, so req_ch.ready drops only once the skid holds a stalled response.
// Reset (synchronous) clears the parser, the error flag and the span tracking.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_decoder_core (
   input  wire logic  clock,
   input  wire logic  reset,
   ihrd_req_if.sink   req_ch,
   ihrd_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      MODE_HEADER,
      MODE_DATA,
      MODE_SKIP,
      MODE_FAULT
   } line_mode_type;

   localparam int unsigned PW = ihrd_pkg::LINE_POS_W;
   localparam int unsigned AW = ihrd_pkg::ADDR_W;
   localparam int unsigned SW = ihrd_pkg::SPAN_W;

   localparam logic [PW-1:0] POS_COLON     = PW'(0);
   localparam logic [PW-1:0] POS_COUNT_END = PW'(2);
   localparam logic [PW-1:0] POS_ADDR_END  = PW'(6);
   localparam logic [PW-1:0] POS_HDR_END   = PW'(8);
   localparam logic [PW-1:0] POS_MIN_LINE  = PW'(ihrd_pkg::MIN_LINE);
   localparam logic [PW-1:0] POS_LAST      = PW'(ihrd_pkg::MAX_LINE - 1);
   localparam logic [SW-1:0] IMAGE_SIZE    = SW'(ihrd_pkg::IMAGE_BYTES);

   // Parser state.
   logic [PW-1:0]  line_position_ff, line_position_in;
   logic [3:0]     high_nibble_ff, high_nibble_in;
   logic [7:0]     record_count_ff, record_count_in;
   logic [AW-1:0]  record_address_ff, record_address_in;
   logic [7:0]     record_kind_ff, record_kind_in;
   logic [7:0]     running_sum_ff, running_sum_in;
   logic [7:0]     data_index_ff, data_index_in;
   line_mode_type  line_mode_ff, line_mode_in;
   logic           error_latched_ff, error_latched_in;
   logic [SW-1:0]  lowest_start_ff, lowest_start_in;
   logic [SW-1:0]  highest_end_ff, highest_end_in;

   // Response register and skid entry.
   ihrd_pkg::rsp_fields_type rsp_ff, rsp_in, skid_ff, skid_in, res;
   logic rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   logic res_valid;

   logic                    accept, take;
   ihrd_pkg::hex_digit_type dig;
   logic [7:0]              byte_val;
   logic [7:0]              kind_next;
   logic [SW-1:0]           record_end;

   assign accept = req_ch.valid & ~skid_valid_ff;
   assign take   = rsp_valid_ff & rsp_ch.ready;
   assign req_ch.ready = ~skid_valid_ff;

   assign dig        = ihrd_pkg::hex_digit(req_ch.char_code);
   assign byte_val   = {high_nibble_ff, dig.value};
   assign kind_next  = {record_kind_ff[3:0], dig.value};
   assign record_end = {1'b0, record_address_ff} + {{(SW-8){1'b0}}, record_count_ff};

   always_comb begin
      line_position_in  = line_position_ff;
      high_nibble_in    = high_nibble_ff;
      record_count_in   = record_count_ff;
      record_address_in = record_address_ff;
      record_kind_in    = record_kind_ff;
      running_sum_in    = running_sum_ff;
      data_index_in     = data_index_ff;
      line_mode_in      = line_mode_ff;
      error_latched_in  = error_latched_ff;
      lowest_start_in   = lowest_start_ff;
      highest_end_in    = highest_end_ff;
      res               = '0;
      res_valid         = 1'b0;

      if (accept) begin
         if (req_ch.end_of_file) begin
            res_valid   = 1'b1;
            res.kind    = ihrd_pkg::KIND_REPORT;
            res.file_ok = ~error_latched_ff;
            if (!error_latched_ff) begin
               res.start_address = lowest_start_ff;
               if (highest_end_ff > lowest_start_ff) begin
                  res.image_length = highest_end_ff - lowest_start_ff;
               end
            end
            line_position_in  = '0;
            high_nibble_in    = '0;
            record_count_in   = '0;
            record_address_in = '0;
            record_kind_in    = '0;
            running_sum_in    = '0;
            data_index_in     = '0;
            line_mode_in      = MODE_HEADER;
            error_latched_in  = 1'b0;
            lowest_start_in   = IMAGE_SIZE;
            highest_end_in    = '0;
         end else if (!error_latched_ff) begin
            if (req_ch.char_code == ihrd_pkg::CHAR_LF) begin
               if (line_position_ff < POS_MIN_LINE || line_mode_ff == MODE_FAULT ||
                   line_mode_ff == MODE_DATA) begin
                  error_latched_in = 1'b1;
               end
               line_position_in  = '0;
               high_nibble_in    = '0;
               record_count_in   = '0;
               record_address_in = '0;
               record_kind_in    = '0;
               running_sum_in    = '0;
               data_index_in     = '0;
               line_mode_in      = MODE_HEADER;
            end else if (line_position_ff >= POS_LAST) begin
               error_latched_in = 1'b1;
            end else begin
               line_position_in = line_position_ff + PW'(1);
               case (line_mode_ff)
                  MODE_HEADER: begin
                     if (line_position_ff == POS_COLON) begin
                        if (req_ch.char_code != ihrd_pkg::CHAR_COLON) begin
                           line_mode_in = MODE_FAULT;
                        end
                     end else if (!dig.is_hex) begin
                        line_mode_in = MODE_SKIP;
                     end else begin
                        // Odd positions carry the high digit of each header byte.
                        if (line_position_ff[0]) begin
                           high_nibble_in = dig.value;
                        end else begin
                           running_sum_in = running_sum_ff + byte_val;
                        end
                        if (line_position_ff <= POS_COUNT_END) begin
                           record_count_in = {record_count_ff[3:0], dig.value};
                        end else if (line_position_ff <= POS_ADDR_END) begin
                           record_address_in = {record_address_ff[AW-5:0], dig.value};
                        end else begin
                           record_kind_in = kind_next;
                        end
                        if (line_position_ff == POS_HDR_END) begin
                           if (kind_next == 8'h00 && record_end <= IMAGE_SIZE) begin
                              if ({1'b0, record_address_ff} < lowest_start_ff) begin
                                 lowest_start_in = {1'b0, record_address_ff};
                              end
                              if (record_end > highest_end_ff) begin
                                 highest_end_in = record_end;
                              end
                              data_index_in = '0;
                              line_mode_in  = MODE_DATA;
                           end else begin
                              line_mode_in = MODE_SKIP;
                           end
                        end
                     end
                  end
                  MODE_DATA: begin
                     if (!dig.is_hex) begin
                        line_mode_in = MODE_FAULT;
                     end else if (line_position_ff[0]) begin
                        high_nibble_in = dig.value;
                     end else if (data_index_ff < record_count_ff) begin
                        res_valid         = 1'b1;
                        res.kind          = ihrd_pkg::KIND_WRITE;
                        res.write_address = record_address_ff + {{(AW-8){1'b0}}, data_index_ff};
                        res.write_byte    = byte_val;
                        running_sum_in    = running_sum_ff + byte_val;
                        data_index_in     = data_index_ff + 8'd1;
                     end else begin
                        // This byte is the checksum: the whole record must sum to zero.
                        if (((running_sum_ff + byte_val) & ihrd_pkg::BYTE_MASK) != 8'h00) begin
                           line_mode_in = MODE_FAULT;
                        end else begin
                           line_mode_in = MODE_SKIP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = res;
            rsp_valid_in = res_valid;
         end
      end else if (!rsp_valid_ff) begin
         rsp_in       = res;
         rsp_valid_in = res_valid;
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_position_ff  <= '0;
         high_nibble_ff    <= '0;
         record_count_ff   <= '0;
         record_address_ff <= '0;
         record_kind_ff    <= '0;
         running_sum_ff    <= '0;
         data_index_ff     <= '0;
         line_mode_ff      <= MODE_HEADER;
         error_latched_ff  <= 1'b0;
         lowest_start_ff   <= IMAGE_SIZE;
         highest_end_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         line_position_ff  <= line_position_in;
         high_nibble_ff    <= high_nibble_in;
         record_count_ff   <= record_count_in;
         record_address_ff <= record_address_in;
         record_kind_ff    <= record_kind_in;
         running_sum_ff    <= running_sum_in;
         data_index_ff     <= data_index_in;
         line_mode_ff      <= line_mode_in;
         error_latched_ff  <= error_latched_in;
         lowest_start_ff   <= lowest_start_in;
         highest_end_ff    <= highest_end_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.kind          = rsp_ff.kind;
   assign rsp_ch.write_address = rsp_ff.write_address;
   assign rsp_ch.write_byte    = rsp_ff.write_byte;
   assign rsp_ch.file_ok       = rsp_ff.file_ok;
   assign rsp_ch.start_address = rsp_ff.start_address;
   assign rsp_ch.image_length  = rsp_ff.image_length;

endmodule

`default_nettype wire

// ===== test/intel_hex_record_decoder_core_tb.sv =====
// Testbench for intel_hex_record_decoder_core: streams Intel HEX texts and checks every
// byte write and final report against a cycle-free decoder model kept in this file.
// Depends on ihrd_pkg, ihrd_req_if, ihrd_rsp_if and the decoder RTL.
`timescale 1ns / 1ps

module intel_hex_record_decoder_core_tb;

   localparam int unsigned TEXT_CHARS  = 1800;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_WAIT  = 10;

   typedef enum logic [1:0] {LINE_HEADER, LINE_DATA, LINE_SKIP, LINE_FAULT} line_mode_type;

   typedef enum int {
      FLAW_NONE, FLAW_NO_COLON, FLAW_BAD_HEADER_DIGIT, FLAW_BAD_DATA_DIGIT,
      FLAW_BAD_CHECKSUM, FLAW_TRUNCATED, FLAW_SHORT, FLAW_TRAILING, FLAW_OVERLONG
   } line_flaw_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_file;
   } text_char_type;

   logic clock = 1'b0;
   logic reset;

   ihrd_req_if req_ch ();
   ihrd_rsp_if rsp_ch ();

   intel_hex_record_decoder_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   text_char_type            hex_text[$];
   ihrd_pkg::rsp_fields_type decoded_outputs[$];
   ihrd_pkg::rsp_fields_type oldest_decode;
   text_char_type            next_char;

   // Decoder state, mirrored from the block's behavior.
   logic [10:0]   line_pos;
   logic [3:0]    hi_nib;
   logic [7:0]    rec_count;
   logic [15:0]   rec_addr;
   logic [7:0]    rec_type;
   logic [7:0]    rec_sum;
   logic [7:0]    data_idx;
   line_mode_type line_mode;
   logic          err_flag;
   logic [16:0]   low_start;
   logic [16:0]   high_end;

   logic        req_fire = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned stall_cycles = 0;
   int unsigned fail_count = 0;
   int unsigned texts_built = 0;
   int unsigned chars_sent = 0;
   int unsigned writes_seen = 0;
   int unsigned reports_seen = 0;
   int unsigned clean_reports = 0;
   logic        calm;

   // A stretch in the middle of the run with neither side ever idling.
   assign calm = (cycle_count >= 400) && (cycle_count < 1200);

   function automatic logic [4:0] nibble_of(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return {1'b1, 4'(ch - "0")};
      if (ch >= "A" && ch <= "F") return {1'b1, 4'(ch - "A" + 8'd10)};
      if (ch >= "a" && ch <= "f") return {1'b1, 4'(ch - "a" + 8'd10)};
      return 5'd0;
   endfunction

   task automatic clear_line();
      line_pos  = '0;
      hi_nib    = '0;
      rec_count = '0;
      rec_addr  = '0;
      rec_type  = '0;
      rec_sum   = '0;
      data_idx  = '0;
      line_mode = LINE_HEADER;
   endtask

   task automatic clear_text();
      clear_line();
      err_flag  = 1'b0;
      low_start = 17'(ihrd_pkg::IMAGE_BYTES);
      high_end  = '0;
   endtask

   task automatic decode_char(input logic [7:0] ch, input logic eof);
      ihrd_pkg::rsp_fields_type r;
      logic [4:0]     dig;
      logic [10:0]    pos;
      logic [7:0]     value;
      logic [16:0]    rec_end;
      r = '0;
      if (eof) begin
         r.kind    = ihrd_pkg::KIND_REPORT;
         r.file_ok = !err_flag;
         if (!err_flag) begin
            r.start_address = low_start;
            if (high_end > low_start) r.image_length = high_end - low_start;
         end
         decoded_outputs = {decoded_outputs, r};
         clear_text();
         return;
      end
      if (err_flag) return;
      if (ch == ihrd_pkg::CHAR_LF) begin
         if (line_pos < ihrd_pkg::MIN_LINE || line_mode == LINE_FAULT ||
             line_mode == LINE_DATA) begin
            err_flag = 1'b1;
         end
         clear_line();
         return;
      end
      if (line_pos >= ihrd_pkg::MAX_LINE - 1) begin
         err_flag = 1'b1;
         return;
      end
      pos      = line_pos;
      line_pos = pos + 11'd1;
      dig      = nibble_of(ch);
      case (line_mode)
         LINE_HEADER: begin
            if (pos == 0) begin
               if (ch != ihrd_pkg::CHAR_COLON) line_mode = LINE_FAULT;
            end else if (!dig[4]) begin
               line_mode = LINE_SKIP;
            end else begin
               if (pos[0]) hi_nib = dig[3:0];
               else rec_sum = rec_sum + {hi_nib, dig[3:0]};
               if (pos <= 2) rec_count = {rec_count[3:0], dig[3:0]};
               else if (pos <= 6) rec_addr = {rec_addr[11:0], dig[3:0]};
               else rec_type = {rec_type[3:0], dig[3:0]};
               if (pos == 8) begin
                  rec_end = {1'b0, rec_addr} + 17'(rec_count);
                  if (rec_type == 8'd0 && rec_end <= ihrd_pkg::IMAGE_BYTES) begin
                     if (rec_addr < low_start) low_start = 17'(rec_addr);
                     if (rec_end > high_end) high_end = rec_end;
                     data_idx  = '0;
                     line_mode = LINE_DATA;
                  end else begin
                     line_mode = LINE_SKIP;
                  end
               end
            end
         end
         LINE_DATA: begin
            if (!dig[4]) begin
               line_mode = LINE_FAULT;
            end else if (pos[0]) begin
               hi_nib = dig[3:0];
            end else begin
               value = {hi_nib, dig[3:0]};
               if (data_idx < rec_count) begin
                  r.kind          = ihrd_pkg::KIND_WRITE;
                  r.write_address = rec_addr + 16'(data_idx);
                  r.write_byte    = value;
                  decoded_outputs = {decoded_outputs, r};
                  rec_sum  = rec_sum + value;
                  data_idx = data_idx + 8'd1;
               end else begin
                  // The byte after the data is the checksum; the line sum must wrap to zero.
                  line_mode = (8'(rec_sum + value) != 8'd0) ? LINE_FAULT : LINE_SKIP;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic add_item(input logic [7:0] ch, input logic eof);
      text_char_type c;
      c.char_code   = ch;
      c.end_of_file = eof;
      hex_text = {hex_text, c};
      if (eof) texts_built++;
   endtask

   function automatic logic [7:0] random_char(input bit want_nonhex);
      logic [7:0] c;
      logic [4:0] d;
      do begin
         c = 8'($urandom_range(0, 255));
         d = nibble_of(c);
      end while (c == ihrd_pkg::CHAR_LF || c == ihrd_pkg::CHAR_COLON ||
                 (want_nonhex && d[4]));
      return c;
   endfunction

   task automatic add_record(input int unsigned count, input int unsigned addr,
                             input logic [7:0] rtype, input line_flaw_type flaw,
                             input bit lower, input bit terminate);
      logic [7:0]  fields[$];
      logic [7:0]  line[$];
      logic [7:0]  sum;
      string       s;
      int unsigned cut;
      fields = {8'(count), addr[15:8], addr[7:0], rtype};
      repeat (count) fields = {fields, 8'($urandom_range(0, 255))};
      sum = '0;
      foreach (fields[i]) sum = sum + fields[i];
      fields = {fields, 8'(~sum + 8'd1)};
      if (flaw == FLAW_BAD_CHECKSUM) fields[fields.size() - 1] ^= 8'($urandom_range(1, 255));
      line = {line, ihrd_pkg::CHAR_COLON};
      foreach (fields[i]) begin
         s = lower ? $sformatf("%02x", fields[i]) : $sformatf("%02X", fields[i]);
         line = {line, s[0], s[1]};
      end
      case (flaw)
         FLAW_NO_COLON:         line[0] = random_char(1'b0);
         FLAW_BAD_HEADER_DIGIT: line[$urandom_range(1, 8)] = random_char(1'b1);
         FLAW_BAD_DATA_DIGIT:   line[$urandom_range(9, line.size() - 1)] = random_char(1'b1);
         FLAW_TRUNCATED, FLAW_SHORT: begin
            cut = (flaw == FLAW_SHORT) ? $urandom_range(0, ihrd_pkg::MIN_LINE - 1)
                                       : $urandom_range(1, line.size() - 1);
            while (line.size() > cut) void'(line.pop_back());
         end
         FLAW_TRAILING: repeat ($urandom_range(1, 6)) line = {line, random_char(1'b0)};
         FLAW_OVERLONG: begin
            while (line.size() < ihrd_pkg::MAX_LINE + 4) line = {line, random_char(1'b0)};
         end
         default: ;
      endcase
      if (terminate) line = {line, ihrd_pkg::CHAR_LF};
      foreach (line[i]) add_item(line[i], 1'b0);
   endtask

   task automatic check_field(input string name, input logic [16:0] want,
                              input logic [16:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Requests are decoded in the order the block accepts them.
   always @(posedge clock) begin
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      if (reset) begin
         clear_text();
      end else if (req_ch.valid && req_ch.ready) begin
         decode_char(req_ch.char_code, req_ch.end_of_file);
         chars_sent++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.char_code   <= '0;
         req_ch.end_of_file <= 1'b0;
         rsp_ch.ready       <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
         if (!req_ch.valid || req_fire) begin
            if (hex_text.size() > 0 && (calm || $urandom_range(0, 99) >= 7)) begin
               next_char = hex_text.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.char_code   <= next_char.char_code;
               req_ch.end_of_file <= next_char.end_of_file;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rsp_ch.kind == ihrd_pkg::KIND_WRITE) begin
            writes_seen++;
         end else begin
            reports_seen++;
            if (rsp_ch.file_ok) clean_reports++;
         end
         if (decoded_outputs.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, got kind %0d addr 0x%0h",
                     $time, rsp_ch.kind, rsp_ch.write_address);
            fail_count++;
         end else begin
            oldest_decode = decoded_outputs.pop_front();
            check_field("kind", 17'(oldest_decode.kind), 17'(rsp_ch.kind));
            check_field("write_address", 17'(oldest_decode.write_address),
                        17'(rsp_ch.write_address));
            check_field("write_byte", 17'(oldest_decode.write_byte), 17'(rsp_ch.write_byte));
            check_field("file_ok", 17'(oldest_decode.file_ok), 17'(rsp_ch.file_ok));
            check_field("start_address", oldest_decode.start_address, rsp_ch.start_address);
            check_field("image_length", oldest_decode.image_length, rsp_ch.image_length);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || req_fire || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no request or response moved for %0d cycles", $time, stall_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int unsigned   n_lines;
      int unsigned   count;
      int unsigned   addr;
      logic [7:0]    rtype;
      line_flaw_type flaw;
      bit            overlong_done;
      reset         = 1'b1;
      overlong_done = 1'b0;

      // Directed: empty text, one byte at the very top of the image, a short line.
      add_item(8'hFF, 1'b1);
      add_record(1, 16'hFFFF, 8'h00, FLAW_NONE, 1'b1, 1'b1);
      add_item(8'h00, 1'b1);
      add_item(ihrd_pkg::CHAR_LF, 1'b0);
      add_item(8'h5A, 1'b1);

      // Random texts: mostly good data records, with every kind of broken line mixed in.
      while (hex_text.size() < TEXT_CHARS) begin
         n_lines = $urandom_range(1, 8);
         for (int i = 0; i < n_lines; i++) begin
            flaw = FLAW_NONE;
            if ($urandom_range(0, 99) >= 78) begin
               flaw = line_flaw_type'($urandom_range(FLAW_NO_COLON, FLAW_TRAILING));
            end
            if (!overlong_done && texts_built >= 4) begin
               flaw          = FLAW_OVERLONG;
               overlong_done = 1'b1;
            end
            count = ($urandom_range(0, 99) < 5) ? $urandom_range(17, 255)
                                                : $urandom_range(0, 16);
            case ($urandom_range(0, 9))
               0:       addr = (count == 0) ? 16'hFFFF : ihrd_pkg::IMAGE_BYTES - count;
               1:       addr = $urandom_range(16'hFF00, 16'hFFFF);
               2:       addr = $urandom_range(0, 15);
               default: addr = $urandom_range(0, 16'hFFFF);
            endcase
            rtype = ($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255));
            add_record(count, addr, rtype, flaw, $urandom_range(0, 1), 1'b1);
         end
         if ($urandom_range(0, 9) == 0) begin
            add_record($urandom_range(0, 8), $urandom_range(0, 16'hFFFF), 8'h00,
                       $urandom_range(0, 1) ? FLAW_NONE : FLAW_TRUNCATED,
                       $urandom_range(0, 1), 1'b0);
         end
         add_item(8'($urandom_range(0, 255)), 1'b1);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (hex_text.size() > 0 || req_ch.valid || decoded_outputs.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d characters in %0d texts: %0d byte writes, %0d final reports",
               chars_sent, texts_built, writes_seen, reports_seen);
      $display("of which %0d reported a clean file; %0d mismatches.", clean_reports, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
